>>> hdl/i2cebs_pkg.sv
// ----------------------------------------------------------------------------
// i2cebs_pkg: shared types and codes for the I2C EEPROM byte sequencer
// Holds the command, bus action and phase codes, the field widths, and the
// structs that carry the sequencer context and one result beat.
// ----------------------------------------------------------------------------
package i2cebs_pkg;

   localparam int CMD_W    = 2;
   localparam int ADDR_W   = 16;
   localparam int BYTE_W   = 8;
   localparam int ACTION_W = 3;
   localparam int PHASE_W  = 4;

   // Commands carried on the request side.
   localparam logic [CMD_W-1:0] CMD_DONE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_ARBL  = 2'd3;

   // Bus actions issued toward the I2C controller.
   localparam logic [ACTION_W-1:0] ACT_NONE   = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_START  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_SEND   = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_RSTART = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_RXMODE = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_NACK   = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_STOP   = 3'd6;

   // Sequencer phases.
   localparam logic [PHASE_W-1:0] ST_IDLE   = 4'd0;
   localparam logic [PHASE_W-1:0] ST_START  = 4'd1;
   localparam logic [PHASE_W-1:0] ST_RSTART = 4'd2;
   localparam logic [PHASE_W-1:0] ST_ADDR_H = 4'd3;
   localparam logic [PHASE_W-1:0] ST_ADDR_L = 4'd4;
   localparam logic [PHASE_W-1:0] ST_WRITE  = 4'd5;
   localparam logic [PHASE_W-1:0] ST_DUMMY  = 4'd6;
   localparam logic [PHASE_W-1:0] ST_READ   = 4'd7;
   localparam logic [PHASE_W-1:0] ST_STOP   = 4'd8;

   localparam logic [BYTE_W-1:0] DEVICE_ADDRESS_RESET = 8'hA0;

   typedef struct packed {
      logic [PHASE_W-1:0] seq_state;
      logic               is_read;
      logic [ADDR_W-1:0]  word_address;
      logic [BYTE_W-1:0]  data_byte;
   } i2cebs_ctx_type;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [ADDR_W-1:0] mem_address;
      logic [BYTE_W-1:0] write_data;
      logic [BYTE_W-1:0] rx_byte;
   } i2cebs_req_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [BYTE_W-1:0]   tx_byte;
      logic [BYTE_W-1:0]   read_data;
      logic                done_res;
      logic [PHASE_W-1:0]  phase;
   } i2cebs_rsp_type;

endpackage

>>> hdl/i2c_eeprom_byte_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_eeprom_byte_sequencer: master-side I2C EEPROM single-byte access
// A request beat is held in the input stage; its result beat is registered.
// Throughput: one request beat per cycle while the result side takes beats.
// Every request beat gives exactly one result beat.
// Reset (synchronous, active high) empties both stages, returns the sequencer
// to idle, clears its context and loads the device address register with 0xA0.
// ----------------------------------------------------------------------------
module i2c_eeprom_byte_sequencer (
   input  logic        clock,
   input  logic        reset,
   // Configuration: device address byte with the direction bit clear.
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] mem_address, [23:16] write_data,
                                    // [31:24] rx_byte
   input  logic [1:0]  req_tuser,   // [1:0] command
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] tx_byte, [15:8] read_data,
                                    // [19:16] phase, [23:20] zero
   output logic [2:0]  rsp_tuser,   // [2:0] action
   output logic        rsp_tlast    // done_res: the beat that issues the stop
);
   import i2cebs_pkg::*;

   // The design is a two-stage pipe. The input stage holds one request beat;
   // the step logic reads it together with the sequencer context, and when
   // the result register is free (or being emptied this cycle) the context
   // advances and the result is captured. The context therefore moves exactly
   // once per request, in request order, whatever the stalls.

   logic [BYTE_W-1:0] device_address_ff;

   logic              in_valid_ff;
   i2cebs_req_type    in_req_ff;

   i2cebs_ctx_type    ctx_ff;
   i2cebs_ctx_type    ctx_in;

   logic              out_valid_ff;
   i2cebs_rsp_type    out_rsp_ff;
   i2cebs_rsp_type    step_rsp;

   logic              out_free;
   logic              advance;
   logic              req_take;

   // The result register can take a new beat when empty or draining.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   // The input stage accepts when empty or when its beat moves on now.
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   i2cebs_step u_step (
      .ctx            (ctx_ff),
      .req            (in_req_ff),
      .device_address (device_address_ff),
      .ctx_next       (ctx_in),
      .rsp            (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff <= DEVICE_ADDRESS_RESET;
      end else if (csr_wr_en) begin
         device_address_ff <= csr_wr_data;
      end
   end

   // Input stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_req_ff.command     <= req_tuser;
         in_req_ff.mem_address <= req_tdata[15:0];
         in_req_ff.write_data  <= req_tdata[23:16];
         in_req_ff.rx_byte     <= req_tdata[31:24];
      end
   end

   // Sequencer context; read_data reports data_byte, so it resets too.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff <= '{seq_state: ST_IDLE, is_read: 1'b0, word_address: '0,
                     data_byte: '0};
      end else if (advance) begin
         ctx_ff <= ctx_in;
      end
   end

   // Result stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_rsp_ff <= step_rsp;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_rsp_ff.action;
   assign rsp_tlast  = out_rsp_ff.done_res;
   assign rsp_tdata  = {4'd0, out_rsp_ff.phase, out_rsp_ff.read_data,
                        out_rsp_ff.tx_byte};

endmodule

>>> hdl/i2cebs_step.sv
// ----------------------------------------------------------------------------
// i2cebs_step: one sequencer step
// Given the current context and one request, forms the next context and the
// bus action, transmit byte and status of the result beat.
// ----------------------------------------------------------------------------
module i2cebs_step (
   input  i2cebs_pkg::i2cebs_ctx_type     ctx,
   input  i2cebs_pkg::i2cebs_req_type     req,
   input  logic [i2cebs_pkg::BYTE_W-1:0]  device_address,
   output i2cebs_pkg::i2cebs_ctx_type     ctx_next,
   output i2cebs_pkg::i2cebs_rsp_type     rsp
);
   import i2cebs_pkg::*;

   logic [ACTION_W-1:0] action;
   logic [BYTE_W-1:0]   tx_byte;
   logic                done_res;

   always_comb begin
      ctx_next = ctx;
      action   = ACT_NONE;
      tx_byte  = '0;
      done_res = 1'b0;

      if (req.command == CMD_ARBL) begin
         ctx_next.seq_state = ST_IDLE;
      end else if (req.command == CMD_READ || req.command == CMD_WRITE) begin
         // A start is honored only from idle.
         if (ctx.seq_state == ST_IDLE) begin
            ctx_next.is_read      = (req.command == CMD_READ);
            ctx_next.word_address = req.mem_address;
            if (req.command == CMD_WRITE) begin
               ctx_next.data_byte = req.write_data;
            end
            action             = ACT_START;
            tx_byte            = device_address;
            ctx_next.seq_state = ST_ADDR_H;
         end
      end else begin
         case (ctx.seq_state)
            ST_IDLE: begin
            end
            ST_START: begin
               action             = ACT_START;
               tx_byte            = device_address;
               ctx_next.seq_state = ST_ADDR_H;
            end
            ST_ADDR_H: begin
               action             = ACT_SEND;
               tx_byte            = ctx.word_address[ADDR_W-1:BYTE_W];
               ctx_next.seq_state = ST_ADDR_L;
            end
            ST_ADDR_L: begin
               action             = ACT_SEND;
               tx_byte            = ctx.word_address[BYTE_W-1:0];
               ctx_next.seq_state = ctx.is_read ? ST_RSTART : ST_WRITE;
            end
            ST_WRITE: begin
               action             = ACT_SEND;
               tx_byte            = ctx.data_byte;
               ctx_next.seq_state = ST_STOP;
            end
            ST_RSTART: begin
               action             = ACT_RSTART;
               tx_byte            = device_address | 8'h01;
               ctx_next.seq_state = ST_DUMMY;
            end
            ST_DUMMY: begin
               action             = ACT_RXMODE;
               ctx_next.data_byte = req.rx_byte;
               ctx_next.seq_state = ST_READ;
            end
            ST_READ: begin
               action             = ACT_NACK;
               ctx_next.data_byte = req.rx_byte;
               ctx_next.seq_state = ST_STOP;
            end
            ST_STOP: begin
               action             = ACT_STOP;
               done_res           = 1'b1;
               ctx_next.seq_state = ST_IDLE;
            end
            default: begin
               ctx_next.seq_state = ST_IDLE;
            end
         endcase
      end

      rsp.action    = action;
      rsp.tx_byte   = tx_byte;
      rsp.read_data = ctx_next.data_byte;
      rsp.done_res  = done_res;
      rsp.phase     = ctx_next.seq_state;
   end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the I2C EEPROM byte sequencer
// Drives request beats (commands with address, data and received bytes),
// predicts every result beat with a behavioral copy of the sequencer, and
// compares the beats field by field. The run starts with a directed table,
// then goes on with random read and write accesses under several device
// address settings, random idling on both sides and a long result hold-off.
// ----------------------------------------------------------------------------
module tb;
   import i2cebs_pkg::*;

   localparam int CYCLE_LIMIT   = 200_000;
   localparam int HOLD_CYCLES   = 300;
   localparam int PHASE_BEATS   = 210;
   localparam int SETTLE_CYCLES = 4;
   localparam int NUM_SETTINGS  = 6;

   // One row of the directed table. Where typed is set, the expected beat is
   // taken from the row; otherwise the predictor supplies it.
   typedef struct {
      i2cebs_req_type req;
      bit             typed;
      i2cebs_rsp_type rsp;
   } dir_row_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        csr_wr_en   = 1'b0;
   logic [7:0]  csr_wr_data = 8'h00;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata   = '0;
   logic [1:0]  req_tuser   = '0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [23:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   // Predictor state: a copy of the sequencer context and its register.
   logic [BYTE_W-1:0]  device_byte = DEVICE_ADDRESS_RESET;
   logic [PHASE_W-1:0] seq_phase   = ST_IDLE;
   logic               reading     = 1'b0;
   logic [ADDR_W-1:0]  word_addr   = '0;
   logic [BYTE_W-1:0]  data_reg    = '0;

   i2cebs_rsp_type pending_results[$];
   dir_row_type    dir_rows[$];

   // Both sides share one switch for random idling, so the stretch with no
   // idling at all is free of gaps on either side.
   logic gaps_on      = 1'b1;
   logic hold_request = 1'b0;

   int mismatches    = 0;
   int beats_sent    = 0;
   int active_beats  = 0;
   int results_seen  = 0;
   int stops_seen    = 0;
   int cycle_count   = 0;
   int hold_left     = 0;
   bit hold_taken    = 1'b0;

   i2c_eeprom_byte_sequencer u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog: a hung handshake or a lost result beat ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t ns: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic i2cebs_req_type beat(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
                                           logic [BYTE_W-1:0] wdata, logic [BYTE_W-1:0] rx);
      i2cebs_req_type r;
      r.command     = cmd;
      r.mem_address = addr;
      r.write_data  = wdata;
      r.rx_byte     = rx;
      return r;
   endfunction

   function automatic i2cebs_rsp_type result(logic [ACTION_W-1:0] act, logic [BYTE_W-1:0] tx,
                                             logic [BYTE_W-1:0] rd, logic done,
                                             logic [PHASE_W-1:0] ph);
      i2cebs_rsp_type o;
      o.action    = act;
      o.tx_byte   = tx;
      o.read_data = rd;
      o.done_res  = done;
      o.phase     = ph;
      return o;
   endfunction

   // Advances the predicted sequencer by one request beat and returns the
   // result beat that it must produce.
   function automatic i2cebs_rsp_type step_sequencer(i2cebs_req_type r);
      i2cebs_rsp_type o;
      o = result(ACT_NONE, 8'h00, 8'h00, 1'b0, ST_IDLE);
      if (r.command == CMD_ARBL) begin
         // Lost arbitration drops to idle but keeps the latched context.
         seq_phase = ST_IDLE;
      end else if (r.command == CMD_READ || r.command == CMD_WRITE) begin
         // A start only takes effect from idle; while busy it is dropped.
         if (seq_phase == ST_IDLE) begin
            reading   = (r.command == CMD_READ);
            word_addr = r.mem_address;
            if (!reading) begin
               data_reg = r.write_data;
            end
            o.action  = ACT_START;
            o.tx_byte = device_byte;
            seq_phase = ST_ADDR_H;
         end
      end else begin
         case (seq_phase)
            ST_IDLE: begin
            end
            ST_START: begin
               o.action  = ACT_START;
               o.tx_byte = device_byte;
               seq_phase = ST_ADDR_H;
            end
            ST_ADDR_H: begin
               o.action  = ACT_SEND;
               o.tx_byte = word_addr[15:8];
               seq_phase = ST_ADDR_L;
            end
            ST_ADDR_L: begin
               o.action  = ACT_SEND;
               o.tx_byte = word_addr[7:0];
               seq_phase = reading ? ST_RSTART : ST_WRITE;
            end
            ST_WRITE: begin
               o.action  = ACT_SEND;
               o.tx_byte = data_reg;
               seq_phase = ST_STOP;
            end
            ST_RSTART: begin
               o.action  = ACT_RSTART;
               o.tx_byte = device_byte | 8'h01;
               seq_phase = ST_DUMMY;
            end
            ST_DUMMY: begin
               o.action  = ACT_RXMODE;
               data_reg  = r.rx_byte;
               seq_phase = ST_READ;
            end
            ST_READ: begin
               o.action  = ACT_NACK;
               data_reg  = r.rx_byte;
               seq_phase = ST_STOP;
            end
            ST_STOP: begin
               o.action   = ACT_STOP;
               o.done_res = 1'b1;
               seq_phase  = ST_IDLE;
            end
            default: begin
               seq_phase = ST_IDLE;
            end
         endcase
      end
      o.read_data = data_reg;
      o.phase     = seq_phase;
      return o;
   endfunction

   // Offers one request beat and waits for it to be taken. This task only
   // lowers the valid line when a gap is inserted, so back-to-back beats keep it high.
   task automatic send_beat(input i2cebs_req_type r, input bit typed,
                            input i2cebs_rsp_type typed_rsp);
      i2cebs_rsp_type predicted;
      while (gaps_on && $urandom_range(99) < 36) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {r.rx_byte, r.write_data, r.mem_address};
      req_tuser  <= r.command;
      do @(posedge clock); while (!req_tready);
      predicted = step_sequencer(r);
      pending_results.push_back(typed ? typed_rsp : predicted);
      beats_sent++;
      if (predicted.action != ACT_NONE) begin
         active_beats++;
      end
   endtask

   task automatic send_random(input logic [CMD_W-1:0] cmd);
      send_beat(beat(cmd, ADDR_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom)),
                1'b0, '0);
   endtask

   // One EEPROM access: a start command followed by the transfer-complete
   // beats that walk it to the stop, or now and then a lone random command.
   // A stray command is now and then mixed in; a lost arbitration abandons the rest.
   task automatic send_eeprom_access();
      int               pick;
      int               steps;
      logic [CMD_W-1:0] cmd;
      logic [CMD_W-1:0] stray;
      pick = $urandom_range(99);
      if (pick < 12) begin
         send_random(CMD_W'($urandom_range(3)));
         return;
      end
      cmd   = (pick < 56) ? CMD_READ : CMD_WRITE;
      steps = (cmd == CMD_READ) ? 6 : 4;
      send_random(cmd);
      for (int k = 0; k < steps; k++) begin
         if ($urandom_range(99) < 6) begin
            stray = CMD_W'($urandom_range(3));
            send_random(stray);
            if (stray == CMD_ARBL) begin
               return;
            end
         end
         send_random(CMD_DONE);
      end
   endtask

   // Stops offering beats until every expected result has come back, then
   // lets the pipeline run empty.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_device_byte(input logic [BYTE_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      device_byte = value;
   endtask

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         mismatches++;
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
   endtask

   // Result side: checks each accepted beat against the oldest expectation
   // and drives the ready line, including one long hold-off that lets the
   // block fill up and push back on the request side.
   always @(posedge clock) begin
      i2cebs_rsp_type got;
      i2cebs_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = result(rsp_tuser, rsp_tdata[7:0], rsp_tdata[15:8], rsp_tlast,
                      rsp_tdata[19:16]);
         results_seen++;
         if (rsp_tlast) begin
            stops_seen++;
         end
         if (pending_results.size() == 0) begin
            mismatches++;
            $display("%0t ns: result beat with nothing expected, actual action %0d tx %02h",
                     $time, got.action, got.tx_byte);
         end else begin
            want = pending_results.pop_front();
            check_field("action", want.action, got.action);
            check_field("tx_byte", want.tx_byte, got.tx_byte);
            check_field("read_data", want.read_data, got.read_data);
            check_field("done_res", want.done_res, got.done_res);
            check_field("phase", want.phase, got.phase);
         end
      end
      if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_request && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !reset && !(gaps_on && $urandom_range(99) < 36);
      end
   end

   initial begin
      logic [BYTE_W-1:0] settings[NUM_SETTINGS];
      int                phase_start;
      int                directed_beats;

      // Device byte settings: both extremes, one with the direction bit set,
      // the reset value, and two random picks.
      settings[0] = 8'h00;
      settings[1] = 8'hFE;
      settings[2] = 8'h7F;
      settings[3] = BYTE_W'($urandom_range(254));
      settings[4] = DEVICE_ADDRESS_RESET;
      settings[5] = BYTE_W'($urandom_range(254));

      // Directed table. It starts from the reset device byte and walks a
      // full write, a full read, starts while busy, transfer-complete while
      // idle and lost arbitration at several points of an access.
      dir_rows.push_back('{beat(CMD_DONE, 16'h0000, 8'h00, 8'hFF), 1'b1,
                           result(ACT_NONE, 8'h00, 8'h00, 1'b0, ST_IDLE)});
      dir_rows.push_back('{beat(CMD_ARBL, 16'h0000, 8'h00, 8'h00), 1'b1,
                           result(ACT_NONE, 8'h00, 8'h00, 1'b0, ST_IDLE)});
      dir_rows.push_back('{beat(CMD_WRITE, 16'hFFFF, 8'hFF, 8'h00), 1'b1,
                           result(ACT_START, 8'hA0, 8'hFF, 1'b0, ST_ADDR_H)});
      dir_rows.push_back('{beat(CMD_READ, 16'h0000, 8'h00, 8'h00), 1'b1,
                           result(ACT_NONE, 8'h00, 8'hFF, 1'b0, ST_ADDR_H)});
      dir_rows.push_back('{beat(CMD_DONE, 16'h0000, 8'h00, 8'h00), 1'b0, '0});
      dir_rows.push_back('{beat(CMD_DONE, 16'h0000, 8'h00, 8'h00), 1'b0, '0});
      dir_rows.push_back('{beat(CMD_DONE, 16'h0000, 8'h00, 8'h00), 1'b0, '0});
      dir_rows.push_back('{beat(CMD_DONE, 16'h0000, 8'h00, 8'h00), 1'b1,
                           result(ACT_STOP, 8'h00, 8'hFF, 1'b1, ST_IDLE)});
      dir_rows.push_back('{beat(CMD_READ, 16'h0000, 8'h5A, 8'h00), 1'b1,
                           result(ACT_START, 8'hA0, 8'hFF, 1'b0, ST_ADDR_H)});
      dir_rows.push_back('{beat(CMD_DONE, 16'h0000, 8'h00, 8'h00), 1'b0, '0});
      dir_rows.push_back('{beat(CMD_DONE, 16'h0000, 8'h00, 8'h00), 1'b0, '0});
      dir_rows.push_back('{beat(CMD_DONE, 16'h0000, 8'h00, 8'h00), 1'b1,
                           result(ACT_RSTART, 8'hA1, 8'hFF, 1'b0, ST_DUMMY)});
      dir_rows.push_back('{beat(CMD_DONE, 16'h0000, 8'h00, 8'h00), 1'b0, '0});
      dir_rows.push_back('{beat(CMD_DONE, 16'h0000, 8'h00, 8'hC3), 1'b0, '0});
      dir_rows.push_back('{beat(CMD_DONE, 16'h0000, 8'h00, 8'h00), 1'b1,
                           result(ACT_STOP, 8'h00, 8'hC3, 1'b1, ST_IDLE)});
      dir_rows.push_back('{beat(CMD_WRITE, 16'h1234, 8'h00, 8'h00), 1'b0, '0});
      dir_rows.push_back('{beat(CMD_DONE, 16'h0000, 8'h00, 8'h00), 1'b0, '0});
      dir_rows.push_back('{beat(CMD_ARBL, 16'h0000, 8'h00, 8'h00), 1'b1,
                           result(ACT_NONE, 8'h00, 8'h00, 1'b0, ST_IDLE)});
      dir_rows.push_back('{beat(CMD_DONE, 16'h0000, 8'h00, 8'hAA), 1'b1,
                           result(ACT_NONE, 8'h00, 8'h00, 1'b0, ST_IDLE)});
      dir_rows.push_back('{beat(CMD_READ, 16'hA55A, 8'h00, 8'h00), 1'b0, '0});
      dir_rows.push_back('{beat(CMD_DONE, 16'h0000, 8'h00, 8'h00), 1'b0, '0});
      dir_rows.push_back('{beat(CMD_DONE, 16'h0000, 8'h00, 8'h00), 1'b0, '0});
      dir_rows.push_back('{beat(CMD_DONE, 16'h0000, 8'h00, 8'h00), 1'b0, '0});
      dir_rows.push_back('{beat(CMD_ARBL, 16'h0000, 8'h00, 8'h00), 1'b1,
                           result(ACT_NONE, 8'h00, 8'h00, 1'b0, ST_IDLE)});
      dir_rows.push_back('{beat(CMD_WRITE, 16'h8001, 8'h81, 8'h00), 1'b0, '0});

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         send_beat(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
      end
      directed_beats = beats_sent;

      // Random accesses, one block per device byte setting. The register is
      // only rewritten once all results are back. The second setting runs
      // with no idling at all; the third carries the long result hold-off.
      for (int p = 0; p < NUM_SETTINGS; p++) begin
         settle();
         write_device_byte(settings[p]);
         gaps_on      <= (p != 1);
         hold_request <= (p == 2);
         phase_start  = active_beats;
         while (active_beats - phase_start < PHASE_BEATS) begin
            send_eeprom_access();
         end
      end
      settle();

      $display("Sent %0d request beats (%0d from the directed table) under %0d device bytes.",
               beats_sent, directed_beats, NUM_SETTINGS);
      $display("Checked %0d result beats, %0d of them closing an access with a stop.",
               results_seen, stops_seen);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
